@@ rtl/ntfs_run_list_vcn_to_lcn_top_assert.svh @@
// Assertion macros for the run list lookup block.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef NTFS_RUN_LIST_VCN_TO_LCN_TOP_ASSERT_SVH
`define NTFS_RUN_LIST_VCN_TO_LCN_TOP_ASSERT_SVH

// Checked at every rising edge outside reset.
`define NTRL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define NTRL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/ntfsrl_pkg.sv @@
// Shared constants, codes and a helper function for the run list lookup block.
// No dependencies.
`default_nettype none

package ntfsrl_pkg;

  localparam int FIELD_BYTES = 8;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  localparam logic CFG_FIRST_VCN = 1'b0;
  localparam logic CFG_LAST_VCN  = 1'b1;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_END    = 2'd2;
  localparam logic [1:0] ST_SPARSE = 2'd3;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_OFF  = 2'd3;

  typedef logic [63:0] word_t;

  // Sign-extends a little-endian field from its highest kept byte.
  function automatic word_t sext_field(word_t v, logic [3:0] n);
    logic [3:0] k;
    word_t      r;
    k = (n > 4'(FIELD_BYTES)) ? 4'(FIELD_BYTES) : n;
    r = v;
    for (int i = 1; i < 8; i++) begin
      if ((k == 4'(i)) && v[8*i-1]) begin
        r = v | ({64{1'b1}} << (8 * i));
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/ntfs_run_list_vcn_to_lcn_top.sv @@
// Run list lookup: translates a VCN to an LCN from a byte-fed mapping-pairs list.
// Depends on ntfsrl_pkg and ntfs_run_list_vcn_to_lcn_top_assert.svh.
//
//   Channel  Signals                                   Direction  Moves
//   in       in_valid/in_ready, op, query_vcn, run_byte  input      one request
//   out      out_valid/out_ready, status, lcn, clusters  output     one result
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data    input      one register write
//
// A request that ends a lookup has its result registered into the output register.
// A new request is taken in every cycle while the output register is empty or being drained.
// The run offset add and the in-run compare sit in one stage between input and result.
// Reset (rst_n low, synchronous) returns the lookup to idle and clears both VCN bounds.
// An undrained full output register stalls input; configuration writes are always taken.
`default_nettype none

`include "ntfs_run_list_vcn_to_lcn_top_assert.svh"

module ntfs_run_list_vcn_to_lcn_top
  import ntfsrl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [62:0] in_query_vcn,
  input  wire logic [7:0]  in_run_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [62:0]      out_lcn,
  output logic [62:0]      out_run_clusters,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [62:0] cfg_data
);

  logic [62:0] first_r, last_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [3:0]  len_bytes_r, len_bytes_nxt;
  logic [3:0]  off_bytes_r, off_bytes_nxt;
  word_t       run_len_r, run_len_nxt;
  word_t       off_acc_r, off_acc_nxt;
  word_t       run_start_r, run_start_nxt;
  word_t       dist_r, dist_nxt;
  word_t       hb_r, hb_nxt;
  logic        ge_r, ge_nxt;
  logic [62:0] held_r, held_nxt;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [62:0] out_lcn_r, out_clusters_r;

  logic        res_vld;
  logic [1:0]  res_status;
  logic [62:0] res_lcn, res_clusters;

  logic        in_acc;
  logic        keep;
  logic [3:0]  idx_inc;
  word_t       byte_sh, len_full, off_full, fin_len, fin_off, lcn_cand;
  logic        finish, hit;

  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_lcn          = out_lcn_r;
  assign out_run_clusters = out_clusters_r;

  // Bytes beyond the kept field width are consumed but not stored.
  assign keep     = idx_r < 4'(FIELD_BYTES);
  assign byte_sh  = {56'd0, in_run_byte} << {idx_r, 3'b000};
  assign len_full = run_len_r | (keep ? byte_sh : '0);
  assign off_full = off_acc_r | (keep ? byte_sh : '0);
  assign idx_inc  = idx_r + 4'd1;

  // hb_r holds query + running LCN - run start, so the found LCN needs one add.
  assign fin_len  = (phase_r == PH_LEN) ? len_full : run_len_r;
  assign fin_off  = (off_bytes_r == 4'd0) ? '0 : sext_field(off_full, off_bytes_r);
  assign lcn_cand = hb_r + fin_off;
  assign hit      = ge_r && (dist_r < fin_len);

  always_comb begin
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    len_bytes_nxt = len_bytes_r;
    off_bytes_nxt = off_bytes_r;
    run_len_nxt   = run_len_r;
    off_acc_nxt   = off_acc_r;
    run_start_nxt = run_start_r;
    dist_nxt      = dist_r;
    hb_nxt        = hb_r;
    ge_nxt        = ge_r;
    held_nxt      = held_r;
    res_vld       = 1'b0;
    res_status    = ST_FOUND;
    res_lcn       = '0;
    res_clusters  = '0;
    finish        = 1'b0;

    if (in_acc) begin
      if (in_op == OP_BEGIN) begin
        held_nxt = in_query_vcn;
        if ((in_query_vcn < first_r) || (in_query_vcn > last_r)) begin
          phase_nxt  = PH_IDLE;
          res_vld    = 1'b1;
          res_status = ST_RANGE;
        end else begin
          phase_nxt     = PH_HEAD;
          idx_nxt       = 4'd0;
          run_start_nxt = {1'b0, first_r};
          run_len_nxt   = '0;
          hb_nxt        = {1'b0, in_query_vcn} - {1'b0, first_r};
          dist_nxt      = {1'b0, in_query_vcn} - {1'b0, first_r};
          ge_nxt        = 1'b1;
        end
      end else begin
        unique case (phase_r)
          PH_HEAD: begin
            if (in_run_byte == 8'd0) begin
              phase_nxt  = PH_IDLE;
              res_vld    = 1'b1;
              res_status = ST_END;
            end else begin
              len_bytes_nxt = in_run_byte[3:0];
              off_bytes_nxt = in_run_byte[7:4];
              run_len_nxt   = '0;
              off_acc_nxt   = '0;
              idx_nxt       = 4'd0;
              phase_nxt     = (in_run_byte[3:0] != 4'd0) ? PH_LEN : PH_OFF;
              // The previous run's length is retired from the base here.
              hb_nxt        = hb_r - run_len_r;
              dist_nxt      = {1'b0, held_r} - run_start_r;
              ge_nxt        = {1'b0, held_r} >= run_start_r;
            end
          end
          PH_LEN: begin
            run_len_nxt = len_full;
            idx_nxt     = idx_inc;
            if (idx_inc >= len_bytes_r) begin
              idx_nxt = 4'd0;
              if (off_bytes_r == 4'd0) begin
                finish = 1'b1;
              end else begin
                phase_nxt = PH_OFF;
              end
            end
          end
          PH_OFF: begin
            off_acc_nxt = off_full;
            idx_nxt     = idx_inc;
            if (idx_inc >= off_bytes_r) begin
              idx_nxt = 4'd0;
              finish  = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (finish) begin
      if (hit) begin
        phase_nxt    = PH_IDLE;
        res_vld      = 1'b1;
        res_clusters = fin_len[62:0];
        if (off_bytes_r == 4'd0) begin
          res_status = ST_SPARSE;
        end else begin
          res_status = ST_FOUND;
          res_lcn    = lcn_cand[62:0];
        end
      end else begin
        phase_nxt     = PH_HEAD;
        run_start_nxt = run_start_r + fin_len;
        hb_nxt        = lcn_cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= '0;
      last_r      <= '0;
      phase_r     <= PH_IDLE;
      idx_r       <= '0;
      len_bytes_r <= '0;
      off_bytes_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FIRST_VCN: first_r <= cfg_data;
          CFG_LAST_VCN:  last_r  <= cfg_data;
          default: begin
          end
        endcase
      end
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      len_bytes_r <= len_bytes_nxt;
      off_bytes_r <= off_bytes_nxt;
      if (res_vld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    run_len_r   <= run_len_nxt;
    off_acc_r   <= off_acc_nxt;
    run_start_r <= run_start_nxt;
    dist_r      <= dist_nxt;
    hb_r        <= hb_nxt;
    ge_r        <= ge_nxt;
    held_r      <= held_nxt;
    if (res_vld) begin
      out_status_r   <= res_status;
      out_lcn_r      <= res_lcn;
      out_clusters_r <= res_clusters;
    end
  end

  `NTRL_ASSERT(a_len_nonzero, (phase_r == PH_LEN) |-> (len_bytes_r != 4'd0), "length phase with no length bytes")
  `NTRL_ASSERT(a_off_nonzero, (phase_r == PH_OFF) |-> (off_bytes_r != 4'd0), "offset phase with no offset bytes")
  `NTRL_ASSERT(a_len_idx, (phase_r == PH_LEN) |-> (idx_r < len_bytes_r), "length byte index past field")
  `NTRL_ASSERT(a_begin_outcome, (in_valid && in_ready && (in_op == OP_BEGIN)) |=> ((phase_r == PH_HEAD) || (out_valid && (out_status == ST_RANGE))), "begin neither started a walk nor reported out of range")

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the VCN to LCN run list lookup block.
// Depends on ntfsrl_pkg and ntfs_run_list_vcn_to_lcn_top; predicts each result
// from its own run list walker and checks every field as results drain.
`timescale 1ns / 1ps

module tb_top;
  import ntfsrl_pkg::*;

  typedef struct packed {
    logic        op;
    logic [62:0] query;
    logic [7:0]  rbyte;
  } lookup_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [62:0] lcn;
    logic [62:0] clusters;
  } translation_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = OP_BEGIN;
  logic [62:0] in_query_vcn = '0;
  logic [7:0]  in_run_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [62:0] out_lcn;
  logic [62:0] out_run_clusters;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_FIRST_VCN;
  logic [62:0] cfg_data = '0;

  lookup_req_t  req_queue[$];
  translation_t awaited_translations[$];
  logic         in_taken = 1'b0;
  logic         steady = 1'b0;
  int           errors = 0;
  int           stim_count = 0;

  // Walker state used for prediction.
  logic [62:0] bound_first = '0;
  logic [62:0] bound_last = '0;
  logic [1:0]  walk_phase = PH_IDLE;
  logic [3:0]  walk_idx = '0;
  logic [3:0]  len_count = '0;
  logic [3:0]  off_count = '0;
  logic [63:0] len_acc = '0;
  logic [63:0] off_acc = '0;
  logic [63:0] lcn_acc = '0;
  logic [63:0] run_start = '0;
  logic [63:0] query_held = '0;

  ntfs_run_list_vcn_to_lcn_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_query_vcn     (in_query_vcn),
    .in_run_byte      (in_run_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_lcn          (out_lcn),
    .out_run_clusters (out_run_clusters),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  task automatic queue_translation(input logic [1:0] st, input logic [63:0] l,
                                   input logic [63:0] rc);
    translation_t t;
    t.status   = st;
    t.lcn      = l[62:0];
    t.clusters = rc[62:0];
    awaited_translations.push_back(t);
  endtask

  task automatic close_run();
    logic [3:0]  kept;
    logic [63:0] delta;
    logic [63:0] run_pos;
    kept  = (off_count > 4'(FIELD_BYTES)) ? 4'(FIELD_BYTES) : off_count;
    delta = off_acc;
    if (kept != 0 && kept < 8 && off_acc[8*kept-1]) begin
      delta = off_acc | ({64{1'b1}} << (8 * kept));
    end
    if (off_count != 0) begin
      lcn_acc = lcn_acc + delta;
    end
    run_pos = query_held - run_start;
    if (query_held >= run_start && run_pos < len_acc) begin
      if (off_count == 0) begin
        queue_translation(ST_SPARSE, '0, len_acc);
      end else begin
        queue_translation(ST_FOUND, lcn_acc + run_pos, len_acc);
      end
      walk_phase = PH_IDLE;
    end else begin
      run_start  = run_start + len_acc;
      walk_phase = PH_HEAD;
    end
  endtask

  task automatic predict_request(input logic op, input logic [62:0] q, input logic [7:0] b);
    if (op == OP_BEGIN) begin
      query_held = {1'b0, q};
      if (q < bound_first || q > bound_last) begin
        walk_phase = PH_IDLE;
        queue_translation(ST_RANGE, '0, '0);
      end else begin
        lcn_acc    = '0;
        run_start  = {1'b0, bound_first};
        walk_idx   = '0;
        walk_phase = PH_HEAD;
      end
    end else begin
      case (walk_phase)
        PH_HEAD: begin
          if (b == 8'h00) begin
            walk_phase = PH_IDLE;
            queue_translation(ST_END, '0, '0);
          end else begin
            len_count  = b[3:0];
            off_count  = b[7:4];
            len_acc    = '0;
            off_acc    = '0;
            walk_idx   = '0;
            walk_phase = (len_count != 0) ? PH_LEN : PH_OFF;
          end
        end
        PH_LEN: begin
          if (walk_idx < FIELD_BYTES) begin
            len_acc[8*walk_idx +: 8] = b;
          end
          walk_idx = walk_idx + 4'd1;
          if (walk_idx >= len_count) begin
            walk_idx = '0;
            if (off_count == 0) begin
              close_run();
            end else begin
              walk_phase = PH_OFF;
            end
          end
        end
        PH_OFF: begin
          if (walk_idx < FIELD_BYTES) begin
            off_acc[8*walk_idx +: 8] = b;
          end
          walk_idx = walk_idx + 4'd1;
          if (walk_idx >= off_count) begin
            walk_idx = '0;
            close_run();
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  // Monitor: tracks register writes and accepted requests, and checks results.
  always @(posedge clk) begin : monitor
    translation_t t;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FIRST_VCN) begin
          bound_first = cfg_data;
        end else begin
          bound_last = cfg_data;
        end
      end
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        predict_request(in_op, in_query_vcn, in_run_byte);
      end
      if (out_valid && out_ready) begin
        if (awaited_translations.size() == 0) begin
          report_mismatch("unrequested result status", 64'(out_status), '0);
        end else begin
          t = awaited_translations.pop_front();
          if (out_status != t.status) begin
            report_mismatch("status", 64'(out_status), 64'(t.status));
          end
          if (out_lcn != t.lcn) begin
            report_mismatch("lcn", 64'(out_lcn), 64'(t.lcn));
          end
          if (out_run_clusters != t.clusters) begin
            report_mismatch("run_clusters", 64'(out_run_clusters), 64'(t.clusters));
          end
        end
      end
    end
  end

  // Driver: presents one request at a time and holds it until it is taken.
  always @(negedge clk) begin : driver
    lookup_req_t r;
    if (rst_n && (!in_valid || in_taken)) begin
      if (req_queue.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
        r = req_queue.pop_front();
        in_op        <= r.op;
        in_query_vcn <= r.query;
        in_run_byte  <= r.rbyte;
        in_valid     <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 11);
  end

  task automatic push_req(input logic op, input logic [62:0] q, input logic [7:0] b);
    lookup_req_t r;
    r.op    = op;
    r.query = q;
    r.rbyte = b;
    req_queue.push_back(r);
    stim_count++;
  endtask

  task automatic push_begin(input logic [62:0] q);
    push_req(OP_BEGIN, q, 8'($urandom));
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_req(OP_BYTE, 63'(rand64()), b);
  endtask

  // Queues a well-formed lookup whose runs mostly reach the query.
  task automatic queue_lookup(input logic [62:0] lo, input logic [62:0] hi);
    logic [63:0] pos;
    logic [63:0] q;
    logic [63:0] span;
    logic [63:0] len_val;
    logic [63:0] tmp;
    int          pick;
    int          ln;
    int          on;
    pick = $urandom_range(99);
    span = (hi >= lo) ? 64'(hi - lo) : '0;
    if (pick < 8) begin
      q = rand64() >> 1;
    end else if (pick < 14) begin
      q = {1'b0, lo} + (rand64() % (span + 64'd1));
    end else begin
      q = {1'b0, lo} +
          64'((span < 300) ? $urandom_range(32'(span)) : $urandom_range(300));
    end
    push_begin(q[62:0]);
    if (q < lo || q > hi) begin
      return;
    end
    pos = {1'b0, lo};
    for (int r = 0; r < 8; r++) begin
      if ($urandom_range(99) < 5) begin
        push_byte(8'h00);
        return;
      end
      pick = $urandom_range(99);
      if (pick < 5) begin
        len_val = '0;
      end else if (pick < 15) begin
        len_val = rand64();
      end else begin
        len_val = 64'($urandom_range(1, 120));
      end
      ln  = 0;
      tmp = len_val;
      while (tmp != 0) begin
        ln++;
        tmp = tmp >> 8;
      end
      pick = $urandom_range(99);
      if (pick < 5) begin
        ln = $urandom_range(9, 15);
      end else if (pick < 20) begin
        ln = $urandom_range(ln, 8);
      end
      pick = $urandom_range(99);
      if (pick < 15) begin
        on = 0;
      end else if (pick < 20) begin
        on = $urandom_range(9, 15);
      end else begin
        on = $urandom_range(1, 8);
      end
      if (ln == 0 && on == 0) begin
        on = 1;
      end
      push_byte({on[3:0], ln[3:0]});
      for (int i = 0; i < ln; i++) begin
        push_byte((i < 8) ? len_val[8*i +: 8] : 8'($urandom));
      end
      for (int i = 0; i < on; i++) begin
        push_byte(8'($urandom));
      end
      if (q >= pos && q - pos < len_val) begin
        return;
      end
      pos = pos + len_val;
    end
    if ($urandom_range(1) == 1) begin
      push_byte(8'h00);
    end
  endtask

  task automatic run_random(input logic [62:0] lo, input logic [62:0] hi, input int target);
    int start;
    int pick;
    lookup_req_t r;
    start = stim_count;
    while (stim_count - start < target) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        queue_lookup(lo, hi);
      end else if (pick < 90) begin
        r.op    = 1'($urandom);
        r.query = 63'(rand64());
        r.rbyte = 8'($urandom);
        push_req(r.op, r.query, r.rbyte);
      end else begin
        // A lookup cut short; the next begin drops it.
        push_begin(lo + 63'($urandom_range(20)));
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
      end
    end
  endtask

  task automatic write_reg(input logic idx, input logic [62:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_bounds(input logic [62:0] lo, input logic [62:0] hi);
    write_reg(CFG_FIRST_VCN, lo);
    write_reg(CFG_LAST_VCN, hi);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (req_queue.size() != 0 || in_valid || awaited_translations.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [62:0] lo;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_bounds(63'd100, 63'd1000);
    push_begin(63'd99);
    push_begin({63{1'b1}});
    push_byte(8'h55);
    push_begin(63'd100);
    push_byte(8'h11);
    push_byte(8'h05);
    push_byte(8'h10);
    push_begin(63'd107);
    push_byte(8'h21);
    push_byte(8'h04);
    push_byte(8'h00);
    push_byte(8'h01);
    push_byte(8'h01);
    push_byte(8'h0A);
    push_begin(63'd100);
    push_byte(8'h00);
    push_begin(63'd200);
    push_begin(63'd102);
    push_byte(8'h11);
    push_byte(8'h08);
    push_byte(8'hF0);
    push_begin(63'd100);
    push_byte(8'h10);
    push_byte(8'h20);
    push_byte(8'h91);
    push_byte(8'h05);
    push_byte(8'h01);
    repeat (6) push_byte(8'h00);
    push_byte(8'h80);
    push_byte(8'hFF);
    wait_drained();

    set_bounds(63'd0, {63{1'b1}});
    run_random(63'd0, {63{1'b1}}, 60);
    wait_drained();

    set_bounds(63'd0, 63'd0);
    run_random(63'd0, 63'd0, 50);
    wait_drained();

    set_bounds({63{1'b1}} - 63'd500, {63{1'b1}});
    run_random({63{1'b1}} - 63'd500, {63{1'b1}}, 50);
    wait_drained();

    set_bounds(63'd5000, 63'd4000);
    run_random(63'd5000, 63'd4000, 20);
    wait_drained();

    steady = 1'b1;
    lo = 63'(rand64() >> 2);
    set_bounds(lo, lo + 63'($urandom));
    run_random(lo, lo + 63'($urandom), 75);
    wait_drained();
    steady = 1'b0;

    lo = 63'(rand64());
    set_bounds(lo, 63'(rand64()) | lo);
    run_random(lo, 63'(rand64()) | lo, 75);
    wait_drained();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ ntfs_run_list_vcn_to_lcn_top.f @@
+incdir+rtl
rtl/ntfsrl_pkg.sv
rtl/ntfs_run_list_vcn_to_lcn_top.sv
verif/tb_top.sv
